// File: src/bfba_pkg.sv
// ----------------------------------------------------------------------------
// bfba_pkg
// Shared constants, types and codes of the best-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfba_pkg;

   localparam int MAX_BLOCKS = 16;
   localparam int SIZE_BITS  = 16;

   localparam int IDX_BITS    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int AMOUNT_BITS = 16;
   localparam int BLOCK_BITS  = 4;
   localparam int LEFT_BITS   = 16;
   localparam int CFG_BITS    = 5;
   localparam int CMP_BITS    = (SIZE_BITS > AMOUNT_BITS) ? SIZE_BITS : AMOUNT_BITS;

   localparam logic OP_LOAD = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic                   valid;
      logic                   found;
      logic [IDX_BITS-1:0]    best_idx;
      logic [SIZE_BITS-1:0]   best_val;
      logic [AMOUNT_BITS-1:0] amount;
   } token_type;

   typedef struct packed {
      logic                 en;
      logic [IDX_BITS-1:0]  idx;
      logic [SIZE_BITS-1:0] data;
   } write_type;

endpackage

`default_nettype wire

// File: src/bfba_cell.sv
// ----------------------------------------------------------------------------
// bfba_cell
// One block of the allocator: holds its free space and refines the search
// token as it passes on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module bfba_cell (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [bfba_pkg::IDX_BITS-1:0]      cell_index,
   input  wire logic                               active,
   input  wire bfba_pkg::write_type                wr,
   input  wire bfba_pkg::token_type                tok_in,
   output      bfba_pkg::token_type                tok_out
);

   logic [bfba_pkg::SIZE_BITS-1:0] space_ff;
   bfba_pkg::token_type            tok_ff;
   bfba_pkg::token_type            tok_next_in;
   logic                           fits;
   logic                           better;

   always_comb begin
      fits   = active && (bfba_pkg::CMP_BITS'(space_ff) >=
                          bfba_pkg::CMP_BITS'(tok_in.amount));
      better = fits && (!tok_in.found || (space_ff < tok_in.best_val));
      tok_next_in          = tok_in;
      tok_next_in.found    = tok_in.found || better;
      tok_next_in.best_idx = better ? cell_index : tok_in.best_idx;
      tok_next_in.best_val = better ? space_ff : tok_in.best_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         space_ff <= '0;
         tok_ff   <= '0;
      end else begin
         if (wr.en && (wr.idx == cell_index)) begin
            space_ff <= wr.data;
         end
         tok_ff <= tok_next_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

// File: src/bfba_ctrl.sv
// ----------------------------------------------------------------------------
// bfba_ctrl
// Sequencer of the allocator: takes items, launches the search token,
// writes back the grant and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfba_ctrl (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire logic                                 req_op,
   input  wire logic [3:0]                           req_block_index,
   input  wire logic [bfba_pkg::AMOUNT_BITS-1:0]     req_amount,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   output      logic                                 rsp_granted,
   output      logic [bfba_pkg::BLOCK_BITS-1:0]      rsp_chosen_block,
   output      logic [bfba_pkg::LEFT_BITS-1:0]       rsp_space_left,
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic [bfba_pkg::CFG_BITS-1:0]        csr_data,
   output      logic [bfba_pkg::MAX_BLOCKS-1:0]      active,
   output      bfba_pkg::token_type                  tok_launch,
   input  wire bfba_pkg::token_type                  tok_last,
   output      bfba_pkg::write_type                  wr
);

   bfba_pkg::state_type                state_ff, state_in;
   logic [bfba_pkg::CFG_BITS-1:0]      cfg_ff;
   logic                               rsp_valid_ff;
   logic                               rsp_granted_ff;
   logic [bfba_pkg::BLOCK_BITS-1:0]    rsp_block_ff;
   logic [bfba_pkg::LEFT_BITS-1:0]     rsp_left_ff;
   logic                               res_granted_ff, res_granted_in;
   logic [bfba_pkg::BLOCK_BITS-1:0]    res_block_ff, res_block_in;
   logic [bfba_pkg::LEFT_BITS-1:0]     res_left_ff, res_left_in;
   logic                               res_load;
   logic                               rsp_load;
   logic [bfba_pkg::SIZE_BITS-1:0]     grant_left;

   assign csr_ready = 1'b1;

   always_comb begin
      for (int i = 0; i < bfba_pkg::MAX_BLOCKS; i++) begin
         active[i] = (32'(cfg_ff) > i);
      end
   end

   assign grant_left = bfba_pkg::SIZE_BITS'(bfba_pkg::CMP_BITS'(tok_last.best_val) -
                                            bfba_pkg::CMP_BITS'(tok_last.amount));

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      tok_launch     = '0;
      wr             = '0;
      res_load       = 1'b0;
      res_granted_in = 1'b0;
      res_block_in   = '0;
      res_left_in    = '0;
      rsp_load       = 1'b0;
      case (state_ff)
         bfba_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op == bfba_pkg::OP_LOAD) begin
                  wr.en    = (32'(req_block_index) < bfba_pkg::MAX_BLOCKS);
                  wr.idx   = bfba_pkg::IDX_BITS'(req_block_index);
                  wr.data  = bfba_pkg::SIZE_BITS'(req_amount);
                  res_load = 1'b1;
                  state_in = bfba_pkg::ST_HOLD;
               end else begin
                  tok_launch.valid  = 1'b1;
                  tok_launch.amount = req_amount;
                  state_in          = bfba_pkg::ST_SCAN;
               end
            end
         end
         bfba_pkg::ST_SCAN: begin
            if (tok_last.valid) begin
               res_load = 1'b1;
               if (tok_last.found) begin
                  wr.en          = 1'b1;
                  wr.idx         = tok_last.best_idx;
                  wr.data        = grant_left;
                  res_granted_in = 1'b1;
                  res_block_in   = bfba_pkg::BLOCK_BITS'(tok_last.best_idx);
                  res_left_in    = bfba_pkg::LEFT_BITS'(grant_left);
               end
               state_in = bfba_pkg::ST_HOLD;
            end
         end
         bfba_pkg::ST_HOLD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = bfba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bfba_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfba_pkg::ST_IDLE;
         cfg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            cfg_ff <= csr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         res_granted_ff <= res_granted_in;
         res_block_ff   <= res_block_in;
         res_left_ff    <= res_left_in;
      end
      if (rsp_load) begin
         rsp_granted_ff <= res_granted_ff;
         rsp_block_ff   <= res_block_ff;
         rsp_left_ff    <= res_left_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_chosen_block = rsp_block_ff;
   assign rsp_space_left   = rsp_left_ff;

endmodule

`default_nettype wire

// File: src/best_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit allocator over a row of block cells; a search token walks the row.
//
//  channel   direction   ports
//  req       in          req_valid req_ready req_op req_block_index req_amount
//  rsp       out         rsp_valid rsp_ready rsp_granted rsp_chosen_block
//                        rsp_space_left
//  csr       in          csr_valid csr_ready csr_data (blocks in use)
//
// a request's search token is launched when the request is accepted and walks the row:
// the token steps one cell per cycle, then the result register, the hold state and the output register.
// a load writes its block and goes to the hold state. one item is in flight at a time.
// reset clears every block's free space and the blocks-in-use register.
// a stalled result holds in the output register; the next item is taken
// as soon as the result is handed to it.
// ----------------------------------------------------------------------------
`default_nettype none

module best_fit_block_allocator (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire logic                                 req_op,
   input  wire logic [3:0]                           req_block_index,
   input  wire logic [bfba_pkg::AMOUNT_BITS-1:0]     req_amount,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   output      logic                                 rsp_granted,
   output      logic [bfba_pkg::BLOCK_BITS-1:0]      rsp_chosen_block,
   output      logic [bfba_pkg::LEFT_BITS-1:0]       rsp_space_left,
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic [bfba_pkg::CFG_BITS-1:0]        csr_data
);

   logic [bfba_pkg::MAX_BLOCKS-1:0] active;
   logic [bfba_pkg::MAX_BLOCKS-1:0] tok_valid;
   bfba_pkg::token_type             chain [bfba_pkg::MAX_BLOCKS+1];
   bfba_pkg::write_type             wr;

   bfba_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_block_index  (req_block_index),
      .req_amount       (req_amount),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_granted      (rsp_granted),
      .rsp_chosen_block (rsp_chosen_block),
      .rsp_space_left   (rsp_space_left),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .active           (active),
      .tok_launch       (chain[0]),
      .tok_last         (chain[bfba_pkg::MAX_BLOCKS]),
      .wr               (wr)
   );

   for (genvar i = 0; i < bfba_pkg::MAX_BLOCKS; i++) begin : g_cell
      bfba_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (bfba_pkg::IDX_BITS'(i)),
         .active     (active[i]),
         .wr         (wr),
         .tok_in     (chain[i]),
         .tok_out    (chain[i+1])
      );
      assign tok_valid[i] = chain[i+1].valid;
   end

   // at most one search in the row
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valid))
      else $error("more than one search token in the cell row");

   // no new item while a search walks the row
   a_no_accept_in_scan: assert property (@(posedge clock) disable iff (reset)
      (tok_valid != '0) |-> !req_ready)
      else $error("item taken while a search is in flight");

   // a refused or load result carries zero fields
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_granted) |-> (rsp_chosen_block == '0 && rsp_space_left == '0))
      else $error("refused result with non-zero fields");

   // accepting an item closes the input until its result is out
   a_accept_closes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input still open after an item was taken");

endmodule

`default_nettype wire
